### rtl/core/wms_pkg.sv
// Shared types, constants and width helpers for the moving-window mean and
// standard deviation block. No dependencies.
`default_nettype none

package wms_pkg;

  localparam int DATA_W      = 16;
  localparam int DEF_DEPTH   = 32;
  localparam int COUNT_W     = 6;
  localparam int OUT_TDATA_W = 40;
  localparam logic signed [DATA_W-1:0] FILL_RESET = 16'sd2511;

  // Width helpers, all functions of the window depth.
  function automatic int addr_w(input int depth);
    return $clog2(depth);
  endfunction

  function automatic int cnt_w(input int depth);
    return $clog2(depth + 1);
  endfunction

  function automatic int mag_w(input int depth);
    return DATA_W + addr_w(depth);
  endfunction

  function automatic int sumsq_w(input int depth);
    return 2 * DATA_W - 1 + addr_w(depth);
  endfunction

  function automatic int num_w(input int depth);
    return cnt_w(depth) + sumsq_w(depth);
  endfunction

  function automatic int mdiv_w(input int depth);
    return mag_w(depth) + 2;
  endfunction

  function automatic int root_w(input int depth);
    return (num_w(depth) + 1) / 2;
  endfunction

  function automatic int step_w(input int depth);
    return $clog2(((num_w(depth) > depth) ? num_w(depth) : depth) + 1);
  endfunction

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_DRAIN,
    S_MAG,
    S_MUL,
    S_NSQ,
    S_MDIV,
    S_MEAN,
    S_VLD,
    S_VDIV,
    S_SQLD,
    S_SQRT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic take;       // input beat accepted
    logic fill_wr;    // clear sweep write
    logic rd;         // window read
    logic acc_clr;
    logic mag_ld;
    logic mul_ld;
    logic nsq_ld;
    logic mdiv_ld;
    logic div_step;
    logic mean_ld;
    logic vdiv_ld;
    logic sqrt_ld;
    logic sqrt_step;
    logic res_ld;
  } dp_cmd_t;

endpackage

`default_nettype wire

### rtl/core/window_mean_stddev.sv
// Moving-window mean and sample standard deviation, top level.
// Depends on wms_pkg, wms_ctrl, wms_datapath, wms_ram.
//
// Usage:
//   in_* : one beat per command. in_tuser = 0 adds in_tdata (Q7.8 sample) at
//          the next ring slot; in_tuser = 1 rewrites every slot with the fill
//          value and drops the full flag, keeping the write position.
//   out_*: one beat per input beat: sample count, mean (Q7.8) and sample
//          standard deviation (Q8.8, saturated).
//   cfg_*: write of the clear fill value, which the user must make only while
//          the block is idle; the block itself has no check for it.
// One command is worked at a time; in_tready is high only when idle. An add
// runs the window read (one RAM read per covered sample), the bit-serial
// divider (at depth 32, 23 steps for the mean, 42 for the variance) and the
// square root (21 steps); a clear runs the fill sweep over every slot first.
// The result waits in an output register while the receiver stalls; the next
// command is accepted meanwhile and holds in its last state until the
// register frees up. Reset empties the window, clears the full flag, drops
// out_tvalid and sets the fill value to 9.81; ring contents are not cleared.
`default_nettype none

module window_mean_stddev import wms_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [DATA_W-1:0]      cfg_wr_data,   // clear_fill_value
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [DATA_W-1:0]      in_tdata,      // [15:0] sample
  input  wire logic                   in_tuser,      // [0] cmd
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata      // [5:0] fill_count,
                                                     // [21:6] mean_value,
                                                     // [37:22] std_deviation
);

  localparam int CW   = cnt_w(WINDOW_DEPTH);
  localparam int CNTW = step_w(WINDOW_DEPTH);

  dp_cmd_t         cmd;
  logic [CNTW-1:0] step_idx;
  logic [CW-1:0]   n_cnt;

  wms_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .n_cnt      (n_cnt),
    .cmd        (cmd),
    .step_idx   (step_idx)
  );

  wms_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (in_tuser),
    .in_sample   (in_tdata),
    .cmd         (cmd),
    .step_idx    (step_idx),
    .n_cnt       (n_cnt),
    .res_tdata   (out_tdata)
  );

endmodule

`default_nettype wire

### rtl/core/wms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/core/wms_datapath.sv
// Datapath: sample ring, accumulators, multipliers, shared bit-serial divider
// and square root, result register. Depends on wms_pkg and wms_ram.
`default_nettype none

module wms_datapath import wms_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_DEPTH,
  localparam int CW   = cnt_w(WINDOW_DEPTH),
  localparam int CNTW = step_w(WINDOW_DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [DATA_W-1:0]        cfg_wr_data,
  input  wire logic                     in_cmd,
  input  wire logic [DATA_W-1:0]        in_sample,
  input  wire dp_cmd_t                  cmd,
  input  wire logic [CNTW-1:0]          step_idx,
  output logic      [CW-1:0]            n_cnt,
  output logic      [OUT_TDATA_W-1:0]   res_tdata
);

  localparam int AW   = addr_w(WINDOW_DEPTH);
  localparam int MAGW = mag_w(WINDOW_DEPTH);
  localparam int SQW  = sumsq_w(WINDOW_DEPTH);
  localparam int H    = SQW / 2;
  localparam int PLW  = CW + H;
  localparam int PHW  = CW + SQW - H;
  localparam int NW   = num_w(WINDOW_DEPTH);
  localparam int S2W  = 2 * MAGW;
  localparam int XW   = (NW > S2W) ? NW : S2W;
  localparam int VW   = 2 * CW;
  localparam int DW   = NW;
  localparam int MDW  = mdiv_w(WINDOW_DEPTH);
  localparam int RTW  = root_w(WINDOW_DEPTH);
  localparam int QW   = 2 * RTW;
  localparam int RMW  = RTW + 3;
  localparam int PADW = OUT_TDATA_W - COUNT_W - 2 * DATA_W;

  // window position
  logic [AW-1:0]            last_slot_r;
  logic [AW-1:0]            slot_nxt;
  logic                     slot_valid_r;
  logic                     full_r;
  logic                     wrap;
  logic signed [DATA_W-1:0] fill_r;

  // ram
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic [DATA_W-1:0]        ram_rdata;

  // accumulation
  logic                     rd_v_r;
  logic                     acc_v_r;
  logic signed [DATA_W-1:0] x_in;
  logic signed [2*DATA_W-1:0] sq_full;
  logic signed [DATA_W-1:0] x_r;
  logic [2*DATA_W-2:0]      sq_r;
  logic signed [MAGW-1:0]   sum_r;
  logic [SQW-1:0]           sumsq_r;

  // statistics
  logic                     neg_r;
  logic [MAGW-1:0]          mag_r;
  logic [S2W-1:0]           s2_r;
  logic [PLW-1:0]           plo_r;
  logic [PHW-1:0]           phi_r;
  logic [VW-1:0]            den_r;
  logic [NW-1:0]            nsq_r;
  logic [NW-1:0]            num_r;
  logic [MDW-1:0]           mdiv_num;

  // divider
  logic [DW-1:0]            dq_r;
  logic [VW-1:0]            dr_r;
  logic [VW-1:0]            dv_r;
  logic [VW:0]              dtrial;
  logic                     dge;

  // square root
  logic [QW-1:0]            so_r;
  logic [RTW-1:0]           root_r;
  logic [RMW-1:0]           srem_r;
  logic [RMW-1:0]           srem2;
  logic [RMW-1:0]           strial;
  logic                     sge;

  // results
  logic [DATA_W-1:0]        mean_r;
  logic                     rnd;
  logic [RTW:0]             s1;
  logic [DATA_W-1:0]        std_val;
  logic [OUT_TDATA_W-1:0]   res_r;

  assign wrap     = slot_valid_r && (last_slot_r == AW'(WINDOW_DEPTH - 1));
  assign slot_nxt = (!slot_valid_r || wrap) ? '0 : last_slot_r + 1'b1;

  always_comb begin
    if (full_r) begin
      n_cnt = CW'(WINDOW_DEPTH);
    end else if (slot_valid_r) begin
      n_cnt = CW'(last_slot_r) + CW'(1);
    end else begin
      n_cnt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= 1'b0;
      last_slot_r  <= '0;
      full_r       <= 1'b0;
      fill_r       <= FILL_RESET;
    end else begin
      if (cfg_wr_en) begin
        fill_r <= cfg_wr_data;
      end
      if (cmd.take) begin
        if (!in_cmd) begin
          slot_valid_r <= 1'b1;
          last_slot_r  <= slot_nxt;
          if (wrap) begin
            full_r <= 1'b1;
          end
        end else begin
          full_r <= 1'b0;
        end
      end
    end
  end

  assign ram_we    = (cmd.take && !in_cmd) || cmd.fill_wr;
  assign ram_waddr = cmd.fill_wr ? step_idx[AW-1:0] : slot_nxt;
  assign ram_wdata = cmd.fill_wr ? fill_r : in_sample;

  wms_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (step_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign x_in    = ram_rdata;
  assign sq_full = x_in * x_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      acc_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.rd;
      acc_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      x_r  <= x_in;
      sq_r <= sq_full[2*DATA_W-2:0];
    end
    if (cmd.acc_clr) begin
      sum_r   <= '0;
      sumsq_r <= '0;
    end else if (acc_v_r) begin
      sum_r   <= sum_r + MAGW'(x_r);
      sumsq_r <= sumsq_r + SQW'(sq_r);
    end
  end

  // n*sum(x^2) is split into two partial products and recombined
  assign mdiv_num = MDW'({mag_r, 1'b0}) + MDW'(n_cnt);

  always_ff @(posedge clk) begin
    if (cmd.mag_ld) begin
      neg_r <= sum_r[MAGW-1];
      mag_r <= sum_r[MAGW-1] ? MAGW'(-sum_r) : MAGW'(sum_r);
    end
    if (cmd.mul_ld) begin
      s2_r  <= S2W'(mag_r) * S2W'(mag_r);
      plo_r <= PLW'(n_cnt) * PLW'(sumsq_r[H-1:0]);
      phi_r <= PHW'(n_cnt) * PHW'(sumsq_r[SQW-1:H]);
      den_r <= VW'(n_cnt) * (VW'(n_cnt) - VW'(1));
    end
    if (cmd.nsq_ld) begin
      nsq_r <= NW'({phi_r, {H{1'b0}}}) + NW'(plo_r);
    end
    if (cmd.mean_ld) begin
      num_r <= (XW'(nsq_r) >= XW'(s2_r)) ? NW'(XW'(nsq_r) - XW'(s2_r)) : '0;
    end
  end

  // restoring divider, one quotient bit per step
  assign dtrial = {dr_r, dq_r[DW-1]};
  assign dge    = dtrial >= {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (cmd.mdiv_ld) begin
      dq_r <= DW'(mdiv_num) << (DW - MDW);
      dr_r <= '0;
      dv_r <= VW'({n_cnt, 1'b0});
    end else if (cmd.vdiv_ld) begin
      dq_r <= num_r;
      dr_r <= '0;
      dv_r <= den_r;
    end else if (cmd.div_step) begin
      dq_r <= {dq_r[DW-2:0], dge};
      dr_r <= dge ? VW'(dtrial - {1'b0, dv_r}) : VW'(dtrial);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_ld) begin
      if (n_cnt == '0) begin
        mean_r <= '0;
      end else begin
        mean_r <= neg_r ? -dq_r[DATA_W-1:0] : dq_r[DATA_W-1:0];
      end
    end
  end

  // square root, two radicand bits per step
  assign srem2  = {srem_r[RMW-3:0], so_r[QW-1:QW-2]};
  assign strial = (RMW'(root_r) << 2) | RMW'(1);
  assign sge    = srem2 >= strial;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_ld) begin
      so_r   <= QW'(dq_r);
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.sqrt_step) begin
      so_r   <= so_r << 2;
      root_r <= {root_r[RTW-2:0], sge};
      srem_r <= sge ? srem2 - strial : srem2;
    end
  end

  // round up once the exact variance reaches (root + 1/2)^2
  assign rnd = (srem_r > RMW'(root_r)) ||
               ((srem_r == RMW'(root_r)) && ({dr_r, 2'b00} >= (VW + 2)'(den_r)));
  assign s1  = (RTW + 1)'(root_r) + (RTW + 1)'(rnd);

  always_comb begin
    if (n_cnt <= CW'(1)) begin
      std_val = '0;
    end else if (|s1[RTW:DATA_W]) begin
      std_val = '1;
    end else begin
      std_val = s1[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_r <= {{PADW{1'b0}}, std_val, mean_r, COUNT_W'(n_cnt)};
    end
  end

  assign res_tdata = res_r;

endmodule

`default_nettype wire

### rtl/core/wms_ctrl.sv
// Controller: sequences fill sweep, window read, division, square root and
// result hand-off. Depends on wms_pkg.
`default_nettype none

module wms_ctrl import wms_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_DEPTH,
  localparam int CW   = cnt_w(WINDOW_DEPTH),
  localparam int CNTW = step_w(WINDOW_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic            in_cmd,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  input  wire logic [CW-1:0]   n_cnt,
  output dp_cmd_t              cmd,
  output logic      [CNTW-1:0] step_idx
);

  localparam int DW  = num_w(WINDOW_DEPTH);
  localparam int MDW = mdiv_w(WINDOW_DEPTH);
  localparam int RTW = root_w(WINDOW_DEPTH);

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r;
  logic            out_free;
  logic            take;

  assign take     = (state_r == S_IDLE) && in_tvalid;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          state_nxt = in_cmd ? S_FILL : S_READ;
        end
      end
      S_FILL: begin
        if (cnt_r == CNTW'(WINDOW_DEPTH - 1)) begin
          state_nxt = S_READ;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_READ: begin
        if (cnt_r == CNTW'(n_cnt)) begin
          state_nxt = S_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (cnt_r == CNTW'(1)) begin
          state_nxt = S_MAG;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      S_MAG:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_NSQ;
      S_NSQ: begin
        state_nxt = S_MDIV;
        cnt_nxt   = '0;
      end
      S_MDIV: begin
        if (cnt_r == CNTW'(MDW - 1)) begin
          state_nxt = S_MEAN;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      S_MEAN: state_nxt = S_VLD;
      S_VLD: begin
        state_nxt = S_VDIV;
        cnt_nxt   = '0;
      end
      S_VDIV: begin
        if (cnt_r == CNTW'(DW - 1)) begin
          state_nxt = S_SQLD;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      S_SQLD: begin
        state_nxt = S_SQRT;
        cnt_nxt   = '0;
      end
      S_SQRT: begin
        if (cnt_r == CNTW'(RTW - 1)) begin
          state_nxt = S_OUT;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.take    = take;
        cmd.acc_clr = 1'b1;
      end
      S_FILL:  cmd.fill_wr  = 1'b1;
      S_READ:  cmd.rd       = (cnt_r != CNTW'(n_cnt));
      S_DRAIN: cmd.rd       = 1'b0;
      S_MAG:   cmd.mag_ld   = 1'b1;
      S_MUL:   cmd.mul_ld   = 1'b1;
      S_NSQ: begin
        cmd.nsq_ld  = 1'b1;
        cmd.mdiv_ld = 1'b1;
      end
      S_MDIV:  cmd.div_step = 1'b1;
      S_MEAN:  cmd.mean_ld  = 1'b1;
      S_VLD:   cmd.vdiv_ld  = 1'b1;
      S_VDIV:  cmd.div_step = 1'b1;
      S_SQLD:  cmd.sqrt_ld  = 1'b1;
      S_SQRT:  cmd.sqrt_step = 1'b1;
      S_OUT:   cmd.res_ld   = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign step_idx   = cnt_r;

endmodule

`default_nettype wire

### rtl/core/wms_checker.sv
// Port-level checks for window_mean_stddev, attached by bind.
// Depends on wms_pkg.
`default_nettype none

module wms_checker import wms_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_DEPTH
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while one is in work");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (WINDOW_DEPTH >= 64) || (out_tdata[5:0] <= 6'(WINDOW_DEPTH)))
    else $error("fill count beyond window depth");

  a_std_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[5:0] <= 6'd1) && (WINDOW_DEPTH < 64)
      |-> out_tdata[37:22] == 16'd0)
    else $error("deviation nonzero for one sample or fewer");

  a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[5:0] == 6'd0) && (WINDOW_DEPTH < 64)
      |-> out_tdata[21:6] == 16'd0)
    else $error("mean nonzero for empty window");

endmodule

bind window_mean_stddev wms_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_wms_checker (.*);

`default_nettype wire
